/* sv/gafa_pkg.sv */
// gafa_pkg: types and constants of the glyph atlas frontier allocator
// used by gafa_fit and glyph_atlas_frontier_allocator; depends on nothing

package gafa_pkg;

   localparam int ATLAS_WIDTH  = 512;
   localparam int ATLAS_HEIGHT = 512;
   localparam int ATLAS_COUNT  = 2;

   // field widths of the request and response transactions
   localparam int GLYPH_W = 9;
   localparam int POS_W   = 9;
   localparam int PAD_W   = GLYPH_W + 1;

   // stored coordinates and free room never exceed the atlas size
   localparam int MAX_DIM = (ATLAS_WIDTH > ATLAS_HEIGHT) ? ATLAS_WIDTH : ATLAS_HEIGHT;
   localparam int STORE_W = $clog2(MAX_DIM + 1);
   // compare width covers a stored value plus a padded size
   localparam int CMP_W   = ((STORE_W > PAD_W) ? STORE_W : PAD_W) + 1;
   localparam int INDEX_W = (ATLAS_COUNT > 1) ? $clog2(ATLAS_COUNT) : 1;

   localparam logic [CMP_W-1:0] ATLAS_W_CMP = CMP_W'(ATLAS_WIDTH);
   localparam logic [CMP_W-1:0] ATLAS_H_CMP = CMP_W'(ATLAS_HEIGHT);

   typedef enum logic {
      ACTION_ALLOC = 1'b0,
      ACTION_CLEAR = 1'b1
   } action_type;

   typedef struct packed {
      action_type         action;
      logic [GLYPH_W-1:0] glyph_width;
      logic [GLYPH_W-1:0] glyph_height;
   } req_type;

   typedef struct packed {
      logic             placed;
      logic             atlas_index;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
   } rsp_type;

   typedef struct packed {
      logic               used;
      logic [STORE_W-1:0] row_x;
      logic [STORE_W-1:0] row_y;
      logic [STORE_W-1:0] row_room_w;
      logic [STORE_W-1:0] row_room_h;
      logic [STORE_W-1:0] below_y;
      logic [STORE_W-1:0] below_room_h;
   } atlas_state_type;

   typedef struct packed {
      logic             fit;
      logic [CMP_W-1:0] pos_x;
      logic [CMP_W-1:0] pos_y;
   } fit_type;

endpackage

/* sv/gafa_fit.sv */
// gafa_fit: fit test and frontier update for one atlas
// depends on gafa_pkg

module gafa_fit (
   input  gafa_pkg::atlas_state_type  state,
   input  logic [gafa_pkg::PAD_W-1:0] pw,
   input  logic [gafa_pkg::PAD_W-1:0] ph,
   output gafa_pkg::fit_type          fit,
   output gafa_pkg::atlas_state_type  state_next
);
   import gafa_pkg::*;

   logic [CMP_W-1:0] pw_c;
   logic [CMP_W-1:0] ph_c;
   logic [CMP_W-1:0] row_x_c;
   logic [CMP_W-1:0] row_y_c;
   logic [CMP_W-1:0] room_w_c;
   logic [CMP_W-1:0] room_h_c;
   logic [CMP_W-1:0] below_y_c;
   logic [CMP_W-1:0] below_h_c;
   logic [CMP_W-1:0] row_bottom;
   logic [CMP_W-1:0] below_bottom;
   logic             empty_fit;
   logic             row_fit;
   logic             below_fit;

   assign pw_c      = CMP_W'(pw);
   assign ph_c      = CMP_W'(ph);
   assign row_x_c   = CMP_W'(state.row_x);
   assign row_y_c   = CMP_W'(state.row_y);
   assign room_w_c  = CMP_W'(state.row_room_w);
   assign room_h_c  = CMP_W'(state.row_room_h);
   assign below_y_c = CMP_W'(state.below_y);
   assign below_h_c = CMP_W'(state.below_room_h);

   assign row_bottom   = row_y_c + ph_c;
   assign below_bottom = below_y_c + ph_c;

   assign empty_fit = (pw_c <= ATLAS_W_CMP) && (ph_c <= ATLAS_H_CMP);
   assign row_fit   = (room_w_c >= pw_c) && (room_h_c >= ph_c) && (row_bottom <= ATLAS_H_CMP);
   assign below_fit = (ATLAS_W_CMP >= pw_c) && (below_h_c >= ph_c)
                      && (below_bottom <= ATLAS_H_CMP);

   always_comb begin
      state_next = state;
      fit.fit    = 1'b0;
      fit.pos_x  = '0;
      fit.pos_y  = '0;
      if (!state.used) begin
         if (empty_fit) begin
            fit.fit                 = 1'b1;
            state_next.used         = 1'b1;
            state_next.row_x        = STORE_W'(pw_c);
            state_next.row_y        = '0;
            state_next.row_room_w   = STORE_W'(ATLAS_W_CMP - pw_c);
            state_next.row_room_h   = STORE_W'(ATLAS_H_CMP);
            state_next.below_y      = STORE_W'(ph_c);
            state_next.below_room_h = STORE_W'(ATLAS_H_CMP - ph_c);
         end
      end else if (row_fit) begin
         fit.fit               = 1'b1;
         fit.pos_x             = row_x_c;
         fit.pos_y             = row_y_c;
         state_next.row_x      = STORE_W'(row_x_c + pw_c);
         state_next.row_room_w = STORE_W'(room_w_c - pw_c);
         if (row_bottom > below_y_c) begin
            state_next.below_y = STORE_W'(row_bottom);
         end
      end else if (below_fit) begin
         fit.fit                 = 1'b1;
         fit.pos_y               = below_y_c;
         state_next.row_x        = STORE_W'(pw_c);
         state_next.row_y        = state.below_y;
         state_next.row_room_w   = STORE_W'(ATLAS_W_CMP - pw_c);
         state_next.row_room_h   = state.below_room_h;
         state_next.below_y      = STORE_W'(below_bottom);
         state_next.below_room_h = STORE_W'(below_h_c - ph_c);
      end
   end

endmodule

/* sv/glyph_atlas_frontier_allocator.sv */
// glyph_atlas_frontier_allocator: top level, atlas state, priority select, output skid
// depends on gafa_pkg and gafa_fit
//
//   channel | direction | ports                          | payload
//   req     | in        | req_valid, req_stall, req_data | req_type
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data | rsp_type
//
// one transaction per cycle unless req_stall is high; the response is registered
// the fit test and frontier update of all atlases form one combinational pass
// reset (synchronous) empties every atlas and drops both output entries
// a stalled response moves new work into a one-entry skid; req_stall rises while it is full

module glyph_atlas_frontier_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gafa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gafa_pkg::rsp_type rsp_data
);
   import gafa_pkg::*;

   atlas_state_type atlas_ff [ATLAS_COUNT];
   atlas_state_type atlas_in [ATLAS_COUNT];
   atlas_state_type atlas_next [ATLAS_COUNT];
   fit_type         fit [ATLAS_COUNT];

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             skid_valid_ff;
   rsp_type          skid_data_ff;
   rsp_type          result_in;
   logic [PAD_W-1:0] pw;
   logic [PAD_W-1:0] ph;
   logic             accept;
   logic             take;

   assign pw        = PAD_W'(req_data.glyph_width) + PAD_W'(1);
   assign ph        = PAD_W'(req_data.glyph_height) + PAD_W'(1);
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar a = 0; a < ATLAS_COUNT; a++) begin : g_atlas
      gafa_fit u_fit (
         .state      (atlas_ff[a]),
         .pw         (pw),
         .ph         (ph),
         .fit        (fit[a]),
         .state_next (atlas_next[a])
      );
   end

   // first atlas that fits takes the glyph; a clear request empties every atlas
   always_comb begin
      logic found;
      found     = 1'b0;
      result_in = '0;
      for (int a = 0; a < ATLAS_COUNT; a++) begin
         atlas_in[a] = atlas_ff[a];
         if (req_data.action == ACTION_CLEAR) begin
            atlas_in[a] = '0;
         end else if (!found && fit[a].fit) begin
            found                 = 1'b1;
            atlas_in[a]           = atlas_next[a];
            result_in.placed      = 1'b1;
            result_in.atlas_index = INDEX_W'(a) & INDEX_W'(1);
            result_in.pos_x       = fit[a].pos_x[POS_W-1:0];
            result_in.pos_y       = fit[a].pos_y[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int a = 0; a < ATLAS_COUNT; a++) begin
            atlas_ff[a] <= '0;
         end
      end else begin
         if (accept) begin
            atlas_ff <= atlas_in;
         end
         if (skid_valid_ff) begin
            if (take) begin
               rsp_data_ff   <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (rsp_valid_ff && rsp_stall) begin
               skid_data_ff  <= result_in;
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_data_ff  <= result_in;
               rsp_valid_ff <= 1'b1;
            end
         end else if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
